@@ design/tclru_pkg.sv @@
// shared types and constants for the tile cache with negative ttl
// no dependencies
package tclru_pkg;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotW = $clog2(NumSlots);
  localparam int unsigned CntW = $clog2(NumSlots + 1);
  localparam logic [7:0] EscalateFails = 8'd5;
  localparam logic [7:0] FailSat = 8'd255;

  typedef enum logic [2:0] {
    MODE_GET       = 3'd0,
    MODE_PUT       = 3'd1,
    MODE_PUT_NEG   = 3'd2,
    MODE_BUMP_FAIL = 3'd3,
    MODE_PUT_TEMP  = 3'd4,
    MODE_RESET_FAIL = 3'd5,
    MODE_EVICT_LRU = 3'd6,
    MODE_INVAL_ALL = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_HIT  = 3'd0,
    ST_MISS = 3'd1,
    ST_NEG  = 3'd2,
    ST_DONE = 3'd3,
    ST_NONE = 3'd4
  } status_e;

  localparam logic [1:0] CfgNegTtl = 2'd0;
  localparam logic [1:0] CfgTempShort = 2'd1;
  localparam logic [1:0] CfgTempLong = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  pack_id;
    logic [4:0]  zoom;
    logic [21:0] tile_x;
    logic [21:0] tile_y;
    logic [31:0] now_ms;
    logic [15:0] data_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] hit_handle;
    logic [7:0]  fail_count;
    logic [15:0] released_handle;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EXEC,
    FSM_OUT,
    FSM_INVAL
  } fsm_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic exec;
    logic inval_step;
    logic out_push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic inval_done;
    logic inval_emit;
  } stat_t;

endpackage

@@ design/tclru_datapath.sv @@
// slot storage, sequential scan for match and victims, per-mode update
// depends on tclru_pkg
module tclru_datapath import tclru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  output rsp_t        rsp_o,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i
);

  logic [NumSlots-1:0] used_q, neg_q, temp_q;
  logic [56:0] key_q [NumSlots];
  logic [15:0] handle_q [NumSlots];
  logic [31:0] rec_q [NumSlots];
  logic [31:0] stamp_q [NumSlots];
  logic [7:0]  fail_q [NumSlots];
  logic [31:0] seq_q;
  logic [23:0] neg_ttl_q, tshort_q, tlong_q;

  req_t req_q;
  logic [56:0] key;
  logic [CntW-1:0] idx_q;
  logic [SlotW-1:0] idx;
  logic match_v_q, free_v_q, lru_v_q, dlru_v_q;
  logic [SlotW-1:0] match_q, free_q, lru_q, dlru_q;
  logic [31:0] lru_rec_q, dlru_rec_q;
  logic inval_any_q;
  logic last_slot;
  logic [NumSlots-1:0] emit_vec, later_vec;
  logic emit_cur, emit_later;

  rsp_t rsp_q;
  logic rsp_valid_q;

  assign key = {req_q.pack_id, req_q.zoom, req_q.tile_x, req_q.tile_y};
  assign idx = idx_q[SlotW-1:0];

  // slots that still hold a handle, and those after the current one
  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      emit_vec[i] = used_q[i] && (handle_q[i] != 16'd0);
      later_vec[i] = (SlotW'(i) > idx);
    end
  end

  assign emit_cur = emit_vec[idx];
  assign emit_later = |(emit_vec & later_vec);

  assign last_slot = (idx_q == CntW'(NumSlots - 1));
  assign stat_o.scan_done = last_slot;
  assign stat_o.inval_done = last_slot;
  // a beat per freed handle, or one empty beat at the end when nothing was freed
  assign stat_o.inval_emit = emit_cur || (last_slot && !inval_any_q);

  assign rsp_o = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // execution comb
  logic [SlotW-1:0] s, claim;
  logic [15:0] freed, c_freed;
  logic [31:0] age, seq_inc;
  logic [23:0] ttl;
  logic [7:0] fc_new;

  always_comb begin
    claim = free_v_q ? free_q : lru_q;
    c_freed = handle_q[claim];
    s = match_v_q ? match_q : claim;
    age = req_q.now_ms - stamp_q[s];
    if (temp_q[s]) begin
      ttl = (fail_q[s] >= EscalateFails) ? tlong_q : tshort_q;
    end else begin
      ttl = neg_ttl_q;
    end
    seq_inc = seq_q + 32'd1;
    freed = match_v_q ? handle_q[s] : c_freed;
    fc_new = match_v_q ? fail_q[s] : 8'd0;
    if (fc_new != FailSat) begin
      fc_new = fc_new + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      neg_q <= '0;
      temp_q <= '0;
      seq_q <= '0;
      neg_ttl_q <= 24'd30000;
      tshort_q <= 24'd2000;
      tlong_q <= 24'd5000;
      rsp_valid_q <= 1'b0;
      idx_q <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        handle_q[i] <= '0;
        rec_q[i] <= '0;
        stamp_q[i] <= '0;
        fail_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgNegTtl: neg_ttl_q <= cfg_data_i;
          CfgTempShort: tshort_q <= cfg_data_i;
          CfgTempLong: tlong_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (cmd_i.out_push) begin
        rsp_valid_q <= 1'b1;
      end
      if (cmd_i.load) begin
        req_q <= req_i;
      end
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
        match_v_q <= 1'b0;
        free_v_q <= 1'b0;
        lru_v_q <= 1'b0;
        dlru_v_q <= 1'b0;
        inval_any_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + CntW'(1);
        if (!match_v_q && used_q[idx] && key_q[idx] == key) begin
          match_v_q <= 1'b1;
          match_q <= idx;
        end
        if (!free_v_q && !used_q[idx]) begin
          free_v_q <= 1'b1;
          free_q <= idx;
        end
        if (!lru_v_q || rec_q[idx] < lru_rec_q) begin
          lru_v_q <= 1'b1;
          lru_q <= idx;
          lru_rec_q <= rec_q[idx];
        end
        if (used_q[idx] && handle_q[idx] != 16'd0 &&
            (!dlru_v_q || rec_q[idx] < dlru_rec_q)) begin
          dlru_v_q <= 1'b1;
          dlru_q <= idx;
          dlru_rec_q <= rec_q[idx];
        end
      end
      if (cmd_i.inval_step) begin
        idx_q <= idx_q + CntW'(1);
        rsp_q <= '{ST_DONE, 16'd0, 8'd0, (emit_cur ? handle_q[idx] : 16'd0), !emit_later};
        if (emit_cur) begin
          inval_any_q <= 1'b1;
        end
        if (used_q[idx]) begin
          used_q[idx] <= 1'b0;
          neg_q[idx] <= 1'b0;
          temp_q[idx] <= 1'b0;
          handle_q[idx] <= '0;
          rec_q[idx] <= '0;
          stamp_q[idx] <= '0;
          fail_q[idx] <= '0;
        end
      end
      if (cmd_i.exec) begin
        rsp_q <= '{ST_DONE, 16'd0, 8'd0, 16'd0, 1'b1};
        case (mode_e'(req_q.mode))
          MODE_GET: begin
            if (!match_v_q) begin
              rsp_q.status <= ST_MISS;
            end else if (neg_q[s] || temp_q[s]) begin
              if (age > {8'd0, ttl}) begin
                rsp_q.status <= ST_MISS;
                if (temp_q[s]) begin
                  temp_q[s] <= 1'b0;
                end else begin
                  used_q[s] <= 1'b0;
                  neg_q[s] <= 1'b0;
                  handle_q[s] <= '0;
                  rec_q[s] <= '0;
                  stamp_q[s] <= '0;
                  fail_q[s] <= '0;
                end
              end else begin
                rsp_q.status <= ST_NEG;
              end
            end else begin
              seq_q <= seq_inc;
              rec_q[s] <= seq_inc;
              rsp_q.status <= (handle_q[s] != 16'd0) ? ST_HIT : ST_MISS;
              rsp_q.hit_handle <= handle_q[s];
            end
          end
          MODE_PUT: begin
            rsp_q.released_handle <= (freed == req_q.data_handle) ? 16'd0 : freed;
            used_q[s] <= 1'b1;
            neg_q[s] <= 1'b0;
            temp_q[s] <= 1'b0;
            key_q[s] <= key;
            handle_q[s] <= req_q.data_handle;
            seq_q <= seq_inc;
            rec_q[s] <= seq_inc;
            stamp_q[s] <= '0;
            fail_q[s] <= '0;
          end
          MODE_PUT_NEG: begin
            rsp_q.released_handle <= freed;
            used_q[s] <= 1'b1;
            neg_q[s] <= 1'b1;
            key_q[s] <= key;
            handle_q[s] <= '0;
            seq_q <= seq_inc;
            rec_q[s] <= seq_inc;
            stamp_q[s] <= req_q.now_ms;
            if (!match_v_q) begin
              temp_q[s] <= 1'b0;
              fail_q[s] <= '0;
            end
          end
          MODE_BUMP_FAIL: begin
            rsp_q.fail_count <= fc_new;
            fail_q[s] <= fc_new;
            if (!match_v_q) begin
              rsp_q.released_handle <= c_freed;
              used_q[s] <= 1'b1;
              neg_q[s] <= 1'b0;
              temp_q[s] <= 1'b0;
              key_q[s] <= key;
              handle_q[s] <= '0;
              stamp_q[s] <= '0;
              seq_q <= seq_inc;
              rec_q[s] <= seq_inc;
            end
          end
          MODE_PUT_TEMP: begin
            if (!match_v_q) begin
              rsp_q.status <= ST_NONE;
            end else begin
              rsp_q.released_handle <= handle_q[s];
              temp_q[s] <= 1'b1;
              neg_q[s] <= 1'b0;
              handle_q[s] <= '0;
              stamp_q[s] <= req_q.now_ms;
              seq_q <= seq_inc;
              rec_q[s] <= seq_inc;
            end
          end
          MODE_RESET_FAIL: begin
            if (!match_v_q) begin
              rsp_q.status <= ST_NONE;
            end else begin
              fail_q[s] <= '0;
              temp_q[s] <= 1'b0;
              if (!neg_q[s] && handle_q[s] == 16'd0) begin
                used_q[s] <= 1'b0;
                rec_q[s] <= '0;
                stamp_q[s] <= '0;
              end
            end
          end
          MODE_EVICT_LRU: begin
            if (!dlru_v_q) begin
              rsp_q.status <= ST_NONE;
            end else begin
              rsp_q.released_handle <= handle_q[dlru_q];
              used_q[dlru_q] <= 1'b0;
              neg_q[dlru_q] <= 1'b0;
              temp_q[dlru_q] <= 1'b0;
              handle_q[dlru_q] <= '0;
              rec_q[dlru_q] <= '0;
              stamp_q[dlru_q] <= '0;
              fail_q[dlru_q] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ design/tclru_ctrl.sv @@
// controller state machine sequencing scan, execute and result beats
// depends on tclru_pkg
module tclru_ctrl import tclru_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  [2:0] mode_i,
  input  logic  rsp_busy_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  fsm_e state_q, state_d;
  logic inval_q, inval_d, pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      inval_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inval_q <= inval_d;
      pend_q <= pend_d;
    end
  end

  always_comb begin
    state_d = state_q;
    inval_d = inval_q;
    pend_d = pend_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_clr = 1'b1;
          inval_d = (mode_i == MODE_INVAL_ALL);
          pend_d = 1'b0;
          state_d = (mode_i == MODE_INVAL_ALL) ? FSM_INVAL : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!rsp_busy_i) begin
          cmd_o.exec = 1'b1;
          state_d = FSM_OUT;
        end
      end
      FSM_OUT: begin
        cmd_o.out_push = 1'b1;
        state_d = inval_q ? FSM_INVAL : FSM_IDLE;
        if (inval_q && pend_q) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_INVAL: begin
        // slots in turn, held if busy; beats per freed handle, else an empty one
        if (!rsp_busy_i) begin
          cmd_o.inval_step = 1'b1;
          if (stat_i.inval_done) begin
            if (stat_i.inval_emit) begin
              pend_d = 1'b1;
              state_d = FSM_OUT;
            end else begin
              state_d = FSM_IDLE;
            end
          end else if (stat_i.inval_emit) begin
            state_d = FSM_OUT;
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

endmodule

@@ design/tile_cache_lru_negative_ttl_unit.sv @@
// top level of the tile cache: controller plus datapath
// depends on tclru_pkg, tclru_ctrl, tclru_datapath
// flow: a request is accepted, every slot is scanned in turn, then it executes and the result beat is pushed out
// a new request is taken only after the previous result is pushed; a beat still waiting on the output stalls execution
// invalidate all: every slot is visited in turn, with a result beat per freed handle, or one empty beat if none
// reset: all slots empty, ttl registers at 30000, 2000 and 5000 ms
module tile_cache_lru_negative_ttl_unit import tclru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;
  logic  rsp_valid;

  // wait for the previous beat to drain before producing a new one
  tclru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (in_data_i.mode),
    .rsp_busy_i (rsp_valid && !out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tclru_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (out_data_o),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (out_ready_i)
  );

  assign out_valid_o = rsp_valid;

endmodule
